// File: hdl/jra_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package jra_pkg;

   localparam int SAMPLE_BITS   = 12;
   localparam int ANGLE_BITS    = 16;
   localparam int CORDIC_STAGES = 16;

   // offsets and clamped offsets carry one sign bit over a sample
   localparam int DIFF_BITS  = SAMPLE_BITS + 1;
   localparam int SQ_BITS    = 2 * SAMPLE_BITS;
   localparam int QUAD_BITS  = 4 * SAMPLE_BITS;
   localparam int PROD_BITS  = 2 * SAMPLE_BITS + 1;
   localparam int NORM_BIT   = 40;
   localparam int VEC_BITS   = NORM_BIT + 5;
   localparam int LEN_BITS   = $clog2(PROD_BITS + 1);
   localparam int SHIFT_BITS = $clog2(NORM_BIT + 2);
   localparam int TURN_BITS  = 32;
   localparam int REG_BITS   = 3;

   localparam logic [TURN_BITS-1:0] HALF_TURN  = TURN_BITS'(64'h8000_0000);
   localparam logic [TURN_BITS-1:0] ROUND_HALF = TURN_BITS'(64'h1) << (31 - ANGLE_BITS);

   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_DEAD = 2'd1;
   localparam logic [1:0] STATUS_BAD  = 2'd2;

   localparam logic [REG_BITS-1:0] REG_MID_X    = 3'd0;
   localparam logic [REG_BITS-1:0] REG_MID_Y    = 3'd1;
   localparam logic [REG_BITS-1:0] REG_MIN_X    = 3'd2;
   localparam logic [REG_BITS-1:0] REG_MAX_X    = 3'd3;
   localparam logic [REG_BITS-1:0] REG_MIN_Y    = 3'd4;
   localparam logic [REG_BITS-1:0] REG_MAX_Y    = 3'd5;
   localparam logic [REG_BITS-1:0] REG_DEAD_X   = 3'd6;
   localparam logic [REG_BITS-1:0] REG_DEAD_Y   = 3'd7;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] mid_x;
      logic [SAMPLE_BITS-1:0] mid_y;
      logic [SAMPLE_BITS-1:0] min_x;
      logic [SAMPLE_BITS-1:0] max_x;
      logic [SAMPLE_BITS-1:0] min_y;
      logic [SAMPLE_BITS-1:0] max_y;
      logic [SAMPLE_BITS-1:0] dead_half_x;
      logic [SAMPLE_BITS-1:0] dead_half_y;
   } cfg_type;

   typedef struct packed {
      logic       valid;
      logic [1:0] status;
   } ctrl_type;

   // atan(2^-i) in turns, 32 bits per turn
   function automatic logic [TURN_BITS-1:0] atan_entry(input logic [4:0] idx);
      logic [TURN_BITS-1:0] v;
      case (idx)
         5'd0:  v = 32'h2000_0000;
         5'd1:  v = 32'h12E4_051E;
         5'd2:  v = 32'h09FB_385B;
         5'd3:  v = 32'h0511_11D4;
         5'd4:  v = 32'h028B_0D43;
         5'd5:  v = 32'h0145_D7E1;
         5'd6:  v = 32'h00A2_F61E;
         5'd7:  v = 32'h0051_7C55;
         5'd8:  v = 32'h0028_BE53;
         5'd9:  v = 32'h0014_5F2F;
         5'd10: v = 32'h000A_2F98;
         5'd11: v = 32'h0005_17CC;
         5'd12: v = 32'h0002_8BE6;
         5'd13: v = 32'h0001_45F3;
         5'd14: v = 32'h0000_A2FA;
         5'd15: v = 32'h0000_517D;
         5'd16: v = 32'h0000_28BE;
         5'd17: v = 32'h0000_145F;
         5'd18: v = 32'h0000_0A30;
         5'd19: v = 32'h0000_0518;
         5'd20: v = 32'h0000_028C;
         5'd21: v = 32'h0000_0146;
         5'd22: v = 32'h0000_00A3;
         5'd23: v = 32'h0000_0051;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

// File: hdl/jra_front.sv
`timescale 1ns / 1ps
`default_nettype none
module jra_front (
   input  wire                                       clock,
   input  wire                                       reset,
   input  wire                                       advance,
   input  wire                                       in_valid,
   input  wire        [jra_pkg::SAMPLE_BITS-1:0]     sample_x,
   input  wire        [jra_pkg::SAMPLE_BITS-1:0]     sample_y,
   input  wire jra_pkg::cfg_type                     cfg,
   output jra_pkg::ctrl_type                         out_ctrl,
   output logic signed [jra_pkg::VEC_BITS-1:0]       vec_x,
   output logic signed [jra_pkg::VEC_BITS-1:0]       vec_y,
   output logic                                      half_turn
);

   localparam int SB = jra_pkg::SAMPLE_BITS;
   localparam int DB = jra_pkg::DIFF_BITS;
   localparam int QB = jra_pkg::SQ_BITS;
   localparam int UB = jra_pkg::QUAD_BITS;
   localparam int PB = jra_pkg::PROD_BITS;
   localparam int VB = jra_pkg::VEC_BITS;
   localparam int LB = jra_pkg::LEN_BITS;
   localparam int HB = jra_pkg::SHIFT_BITS;

   // stage 1: offsets, config check, deadzone squares, side ranges
   logic                 v1_ff, bad1_ff;
   logic signed [DB-1:0] dx1_ff, dy1_ff;
   logic [QB-1:0]        hx2_1_ff, hy2_1_ff;
   logic [SB-1:0]        rx1_ff, ry1_ff;
   logic                 bad1_in;
   logic signed [DB-1:0] dx1_in, dy1_in;
   logic [SB-1:0]        rx1_in, ry1_in;

   always_comb begin
      dx1_in  = $signed({1'b0, sample_x}) - $signed({1'b0, cfg.mid_x});
      dy1_in  = $signed({1'b0, sample_y}) - $signed({1'b0, cfg.mid_y});
      bad1_in = (cfg.dead_half_x == '0) || (cfg.dead_half_y == '0) ||
                !((cfg.min_x < cfg.mid_x) && (cfg.mid_x < cfg.max_x)) ||
                !((cfg.min_y < cfg.mid_y) && (cfg.mid_y < cfg.max_y));
      rx1_in  = dx1_in[DB-1] ? (cfg.mid_x - cfg.min_x) : (cfg.max_x - cfg.mid_x);
      ry1_in  = dy1_in[DB-1] ? (cfg.mid_y - cfg.min_y) : (cfg.max_y - cfg.mid_y);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= in_valid;
      end
      if (advance) begin
         bad1_ff  <= bad1_in;
         dx1_ff   <= dx1_in;
         dy1_ff   <= dy1_in;
         hx2_1_ff <= QB'(cfg.dead_half_x) * QB'(cfg.dead_half_x);
         hy2_1_ff <= QB'(cfg.dead_half_y) * QB'(cfg.dead_half_y);
         rx1_ff   <= rx1_in;
         ry1_ff   <= ry1_in;
      end
   end

   // stage 2: offset squares, clamp, deadzone limit
   logic                 v2_ff, bad2_ff;
   logic [QB-1:0]        mx2_ff, my2_ff, hx2_2_ff, hy2_2_ff;
   logic [UB-1:0]        lim2_ff;
   logic signed [DB-1:0] cdx2_ff, cdy2_ff;
   logic [SB-1:0]        rx2_ff, ry2_ff;
   logic [SB-1:0]        mx, my;
   logic signed [DB-1:0] cdx_in, cdy_in;

   always_comb begin
      mx = dx1_ff[DB-1] ? SB'(-dx1_ff) : SB'(dx1_ff);
      my = dy1_ff[DB-1] ? SB'(-dy1_ff) : SB'(dy1_ff);
      cdx_in = dx1_ff;
      if (mx > rx1_ff) begin
         cdx_in = dx1_ff[DB-1] ? -$signed({1'b0, rx1_ff}) : $signed({1'b0, rx1_ff});
      end
      cdy_in = dy1_ff;
      if (my > ry1_ff) begin
         cdy_in = dy1_ff[DB-1] ? -$signed({1'b0, ry1_ff}) : $signed({1'b0, ry1_ff});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (advance) begin
         v2_ff <= v1_ff;
      end
      if (advance) begin
         bad2_ff  <= bad1_ff;
         mx2_ff   <= QB'(mx) * QB'(mx);
         my2_ff   <= QB'(my) * QB'(my);
         lim2_ff  <= UB'(hx2_1_ff) * UB'(hy2_1_ff);
         hx2_2_ff <= hx2_1_ff;
         hy2_2_ff <= hy2_1_ff;
         cdx2_ff  <= cdx_in;
         cdy2_ff  <= cdy_in;
         rx2_ff   <= rx1_ff;
         ry2_ff   <= ry1_ff;
      end
   end

   // stage 3: deadzone terms and cross-scaled vector
   logic                 v3_ff, bad3_ff;
   logic [UB-1:0]        t1_3_ff, t2_3_ff, lim3_ff;
   logic signed [PB-1:0] x3_ff, y3_ff;
   logic signed [PB-1:0] cdx_w, cdy_w, rx_w, ry_w;

   always_comb begin
      cdx_w = PB'(cdx2_ff);
      cdy_w = PB'(cdy2_ff);
      rx_w  = $signed(PB'(rx2_ff));
      ry_w  = $signed(PB'(ry2_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (advance) begin
         v3_ff <= v2_ff;
      end
      if (advance) begin
         bad3_ff <= bad2_ff;
         t1_3_ff <= UB'(mx2_ff) * UB'(hy2_2_ff);
         t2_3_ff <= UB'(my2_ff) * UB'(hx2_2_ff);
         lim3_ff <= lim2_ff;
         x3_ff   <= cdx_w * ry_w;
         y3_ff   <= cdy_w * rx_w;
      end
   end

   // stage 4: classify, fold into right half plane, find normalizing shift
   logic                 v4_ff, half4_ff;
   logic [1:0]           status4_ff;
   logic signed [PB-1:0] x4_ff, y4_ff;
   logic [HB-1:0]        sh4_ff;
   logic [UB:0]          dz_sum;
   logic [1:0]           status_in;
   logic [PB-2:0]        ax, ay, mag_or;
   logic [LB-1:0]        len;

   always_comb begin
      dz_sum = {1'b0, t1_3_ff} + {1'b0, t2_3_ff};
      if (bad3_ff) begin
         status_in = jra_pkg::STATUS_BAD;
      end else if (dz_sum <= {1'b0, lim3_ff}) begin
         status_in = jra_pkg::STATUS_DEAD;
      end else begin
         status_in = jra_pkg::STATUS_OK;
      end
      ax = x3_ff[PB-1] ? (PB-1)'(-x3_ff) : x3_ff[PB-2:0];
      ay = y3_ff[PB-1] ? (PB-1)'(-y3_ff) : y3_ff[PB-2:0];
      mag_or = ax | ay;
      len = '0;
      for (int i = 0; i < PB - 1; i++) begin
         if (mag_or[i]) begin
            len = LB'(i + 1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (advance) begin
         v4_ff <= v3_ff;
      end
      if (advance) begin
         status4_ff <= status_in;
         half4_ff   <= x3_ff[PB-1];
         x4_ff      <= x3_ff[PB-1] ? -x3_ff : x3_ff;
         y4_ff      <= x3_ff[PB-1] ? -y3_ff : y3_ff;
         sh4_ff     <= HB'(jra_pkg::NORM_BIT + 1) - HB'(len);
      end
   end

   // stage 5: normalize
   logic             v5_ff, half5_ff;
   logic [1:0]       status5_ff;
   logic signed [VB-1:0] x5_ff, y5_ff;
   logic signed [VB-1:0] x_ext, y_ext;

   always_comb begin
      x_ext = VB'(x4_ff);
      y_ext = VB'(y4_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (advance) begin
         v5_ff <= v4_ff;
      end
      if (advance) begin
         status5_ff <= status4_ff;
         half5_ff   <= half4_ff;
         x5_ff      <= x_ext <<< sh4_ff;
         y5_ff      <= y_ext <<< sh4_ff;
      end
   end

   assign out_ctrl.valid  = v5_ff;
   assign out_ctrl.status = status5_ff;
   assign vec_x           = x5_ff;
   assign vec_y           = y5_ff;
   assign half_turn       = half5_ff;

endmodule
`default_nettype wire

// File: hdl/jra_cordic.sv
`timescale 1ns / 1ps
`default_nettype none
module jra_cordic (
   input  wire                                     clock,
   input  wire                                     reset,
   input  wire                                     advance,
   input  wire jra_pkg::ctrl_type                  in_ctrl,
   input  wire signed [jra_pkg::VEC_BITS-1:0]      vec_x,
   input  wire signed [jra_pkg::VEC_BITS-1:0]      vec_y,
   input  wire                                     half_turn,
   output jra_pkg::ctrl_type                       out_ctrl,
   output logic [jra_pkg::TURN_BITS-1:0]           angle
);

   localparam int N  = jra_pkg::CORDIC_STAGES;
   localparam int VB = jra_pkg::VEC_BITS;
   localparam int TB = jra_pkg::TURN_BITS;

   jra_pkg::ctrl_type    ctrl_ff [N];
   logic signed [VB-1:0] x_ff    [N];
   logic signed [VB-1:0] y_ff    [N];
   logic [TB-1:0]        z_ff    [N];

   jra_pkg::ctrl_type    src_ctrl [N];
   logic signed [VB-1:0] src_x    [N];
   logic signed [VB-1:0] src_y    [N];
   logic [TB-1:0]        src_z    [N];

   for (genvar i = 0; i < N; i++) begin : g_stage
      if (i == 0) begin : g_head
         assign src_ctrl[i] = in_ctrl;
         assign src_x[i]    = vec_x;
         assign src_y[i]    = vec_y;
         assign src_z[i]    = half_turn ? jra_pkg::HALF_TURN : '0;
      end else begin : g_link
         assign src_ctrl[i] = ctrl_ff[i-1];
         assign src_x[i]    = x_ff[i-1];
         assign src_y[i]    = y_ff[i-1];
         assign src_z[i]    = z_ff[i-1];
      end

      // rotate toward the x axis, floor shifts
      always_ff @(posedge clock) begin
         if (reset) begin
            ctrl_ff[i].valid <= 1'b0;
         end else if (advance) begin
            ctrl_ff[i].valid <= src_ctrl[i].valid;
         end
         if (advance) begin
            ctrl_ff[i].status <= src_ctrl[i].status;
            if (!src_y[i][VB-1]) begin
               x_ff[i] <= src_x[i] + (src_y[i] >>> i);
               y_ff[i] <= src_y[i] - (src_x[i] >>> i);
               z_ff[i] <= src_z[i] + jra_pkg::atan_entry(5'(i));
            end else begin
               x_ff[i] <= src_x[i] - (src_y[i] >>> i);
               y_ff[i] <= src_y[i] + (src_x[i] >>> i);
               z_ff[i] <= src_z[i] - jra_pkg::atan_entry(5'(i));
            end
         end
      end
   end

   assign out_ctrl = ctrl_ff[N-1];
   assign angle    = z_ff[N-1];

endmodule
`default_nettype wire

// File: hdl/joystick_radial_angle.sv
// joystick_radial_angle: direction of a joystick deflection as a fraction of a turn.
//
// Request channel (req_*): one sample pair, sample_x and sample_y, accepted at a
// rising edge with req_valid high and req_stall low. Response channel (rsp_*): one
// response per request, in order, with status (0 angle valid, 1 inside deadzone,
// 2 invalid configuration) and angle (counterclockwise from +x, 65536 per
// turn, zero unless status is 0).
// Configuration: APB-style port, registers at byte address 4*i (mid_x,
// mid_y, min_x, max_x, min_y, max_y, dead_half_x, dead_half_y). Write only
// while no request is in flight.
// Pipeline: five front stages (offsets, squares, products, classify, normalize),
// one per CORDIC iteration (16) and the rounding output register. Throughput:
// one request per cycle unless the receiver stalls a held response.
// Stall: when the output register holds a response that the receiver stalls, the
// whole pipeline holds and req_stall rises in the same cycle; nothing is lost.
// Reset: synchronous, active high; clears all valid bits and loads the
// configuration reset values. No clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module joystick_radial_angle (
   input  wire                                    clock,
   input  wire                                    reset,
   input  wire                                    req_valid,
   output logic                                   req_stall,
   input  wire  [jra_pkg::SAMPLE_BITS-1:0]        req_sample_x,
   input  wire  [jra_pkg::SAMPLE_BITS-1:0]        req_sample_y,
   output logic                                   rsp_valid,
   input  wire                                    rsp_stall,
   output logic [1:0]                             rsp_status,
   output logic [jra_pkg::ANGLE_BITS-1:0]         rsp_angle,
   input  wire                                    csr_psel,
   input  wire                                    csr_penable,
   input  wire                                    csr_pwrite,
   input  wire  [4:0]                             csr_paddr,
   input  wire  [31:0]                            csr_pwdata,
   output logic [31:0]                            csr_prdata,
   output logic                                   csr_pready
);

   localparam int SB = jra_pkg::SAMPLE_BITS;
   localparam int AB = jra_pkg::ANGLE_BITS;
   localparam int TB = jra_pkg::TURN_BITS;

   // configuration registers
   jra_pkg::cfg_type cfg_ff;
   logic [jra_pkg::REG_BITS-1:0] reg_idx;
   logic [SB-1:0] wr_val;
   logic          wr_en;

   assign reg_idx    = csr_paddr[4:2];
   assign wr_val     = csr_pwdata[SB-1:0];
   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mid_x       <= SB'(2048);
         cfg_ff.mid_y       <= SB'(2048);
         cfg_ff.min_x       <= '0;
         cfg_ff.max_x       <= SB'(4095);
         cfg_ff.min_y       <= '0;
         cfg_ff.max_y       <= SB'(4095);
         cfg_ff.dead_half_x <= SB'(256);
         cfg_ff.dead_half_y <= SB'(256);
      end else if (wr_en) begin
         case (reg_idx)
            jra_pkg::REG_MID_X:    cfg_ff.mid_x       <= wr_val;
            jra_pkg::REG_MID_Y:    cfg_ff.mid_y       <= wr_val;
            jra_pkg::REG_MIN_X:    cfg_ff.min_x       <= wr_val;
            jra_pkg::REG_MAX_X:    cfg_ff.max_x       <= wr_val;
            jra_pkg::REG_MIN_Y:    cfg_ff.min_y       <= wr_val;
            jra_pkg::REG_MAX_Y:    cfg_ff.max_y       <= wr_val;
            jra_pkg::REG_DEAD_X:   cfg_ff.dead_half_x <= wr_val;
            jra_pkg::REG_DEAD_Y:   cfg_ff.dead_half_y <= wr_val;
            default: ;
         endcase
      end
   end

   // read back: zero-extend the selected register
   always_comb begin
      case (reg_idx)
         jra_pkg::REG_MID_X:    csr_prdata = 32'(cfg_ff.mid_x);
         jra_pkg::REG_MID_Y:    csr_prdata = 32'(cfg_ff.mid_y);
         jra_pkg::REG_MIN_X:    csr_prdata = 32'(cfg_ff.min_x);
         jra_pkg::REG_MAX_X:    csr_prdata = 32'(cfg_ff.max_x);
         jra_pkg::REG_MIN_Y:    csr_prdata = 32'(cfg_ff.min_y);
         jra_pkg::REG_MAX_Y:    csr_prdata = 32'(cfg_ff.max_y);
         jra_pkg::REG_DEAD_X:   csr_prdata = 32'(cfg_ff.dead_half_x);
         jra_pkg::REG_DEAD_Y:   csr_prdata = 32'(cfg_ff.dead_half_y);
         default:               csr_prdata = '0;
      endcase
   end

   // output register
   logic          rsp_valid_ff;
   logic [1:0]    rsp_status_ff;
   logic [AB-1:0] rsp_angle_ff;

   // advance every stage unless a finished response is held by the receiver
   logic advance;
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   jra_pkg::ctrl_type front_ctrl, cordic_ctrl;
   logic signed [jra_pkg::VEC_BITS-1:0] vec_x, vec_y;
   logic half_turn;
   logic [TB-1:0] angle_raw, angle_rnd;

   jra_front u_front (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_valid),
      .sample_x  (req_sample_x),
      .sample_y  (req_sample_y),
      .cfg       (cfg_ff),
      .out_ctrl  (front_ctrl),
      .vec_x     (vec_x),
      .vec_y     (vec_y),
      .half_turn (half_turn)
   );

   jra_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_ctrl   (front_ctrl),
      .vec_x     (vec_x),
      .vec_y     (vec_y),
      .half_turn (half_turn),
      .out_ctrl  (cordic_ctrl),
      .angle     (angle_raw)
   );

   // round half up to the output width; a full turn wraps to zero
   assign angle_rnd = angle_raw + jra_pkg::ROUND_HALF;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= cordic_ctrl.valid;
      end
      if (advance) begin
         rsp_status_ff <= cordic_ctrl.status;
         rsp_angle_ff  <= (cordic_ctrl.status == jra_pkg::STATUS_OK) ?
                          angle_rnd[TB-1 -: AB] : '0;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_angle  = rsp_angle_ff;

   // angle is only reported with a valid status
   a_angle_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != jra_pkg::STATUS_OK) |-> rsp_angle_ff == '0)
      else $error("angle nonzero without valid status");

   // the pipeline only holds when the output register is full and stalled
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid_ff && rsp_stall))
      else $error("pipeline held without a stalled response");

   // reset leaves no response pending
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff)
      else $error("response pending after reset");

endmodule
`default_nettype wire

// File: dv/angle_checker.sv
`timescale 1ns / 1ps
module angle_checker (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             req_valid,
   input  wire                             req_stall,
   input  wire [jra_pkg::SAMPLE_BITS-1:0]  req_sample_x,
   input  wire [jra_pkg::SAMPLE_BITS-1:0]  req_sample_y,
   input  wire                             rsp_valid,
   input  wire                             rsp_stall,
   input  wire [1:0]                       rsp_status,
   input  wire [jra_pkg::ANGLE_BITS-1:0]   rsp_angle,
   input  wire                             csr_psel,
   input  wire                             csr_penable,
   input  wire                             csr_pwrite,
   input  wire                             csr_pready,
   input  wire [4:0]                       csr_paddr,
   input  wire [31:0]                      csr_pwdata,
   output int                              fail_count,
   output int                              pending,
   output int                              ok_count,
   output int                              dead_count,
   output int                              bad_count
);
   localparam int SB = jra_pkg::SAMPLE_BITS;
   localparam int AB = jra_pkg::ANGLE_BITS;

   typedef struct packed {
      logic [1:0]    status;
      logic [AB-1:0] angle;
   } angle_result_type;

   jra_pkg::cfg_type cfg;
   angle_result_type angle_queue[$];

   function automatic longint floor_shift(longint v, int k);
      return v >>> k;
   endfunction

   function automatic angle_result_type compute_angle(logic [SB-1:0] sx,
                                                      logic [SB-1:0] sy);
      angle_result_type r;
      longint cx, cy, dx, dy, rx, ry, hx2, hy2, X, Y, nx, ny, ax, ay;
      longint unsigned t1, t2, lim;
      logic [31:0] z;
      r = '0;
      cx = cfg.mid_x; cy = cfg.mid_y;
      if (cfg.dead_half_x == 0 || cfg.dead_half_y == 0 ||
          !(cfg.min_x < cfg.mid_x && cfg.mid_x < cfg.max_x) ||
          !(cfg.min_y < cfg.mid_y && cfg.mid_y < cfg.max_y)) begin
         r.status = jra_pkg::STATUS_BAD;
         return r;
      end
      dx = longint'(sx) - cx;
      dy = longint'(sy) - cy;
      hx2 = longint'(cfg.dead_half_x) * cfg.dead_half_x;
      hy2 = longint'(cfg.dead_half_y) * cfg.dead_half_y;
      t1 = dx * dx * hy2;
      t2 = dy * dy * hx2;
      lim = hx2 * hy2;
      if (t1 <= lim && t2 <= lim - t1) begin
         r.status = jra_pkg::STATUS_DEAD;
         return r;
      end
      rx = dx >= 0 ? longint'(cfg.max_x) - cx : cx - longint'(cfg.min_x);
      ry = dy >= 0 ? longint'(cfg.max_y) - cy : cy - longint'(cfg.min_y);
      if (dx > rx) dx = rx;
      if (dx < -rx) dx = -rx;
      if (dy > ry) dy = ry;
      if (dy < -ry) dy = -ry;
      X = dx * ry;
      Y = dy * rx;
      forever begin
         ax = X < 0 ? -X : X;
         ay = Y < 0 ? -Y : Y;
         if (ax >= (64'sd1 <<< 40) || ay >= (64'sd1 <<< 40)) break;
         X = X * 2;
         Y = Y * 2;
      end
      z = '0;
      if (X < 0) begin
         X = -X;
         Y = -Y;
         z = jra_pkg::HALF_TURN;
      end
      for (int i = 0; i < jra_pkg::CORDIC_STAGES; i++) begin
         if (Y >= 0) begin
            nx = X + floor_shift(Y, i);
            ny = Y - floor_shift(X, i);
            z = z + jra_pkg::atan_entry(5'(i));
         end else begin
            nx = X - floor_shift(Y, i);
            ny = Y + floor_shift(X, i);
            z = z - jra_pkg::atan_entry(5'(i));
         end
         X = nx;
         Y = ny;
      end
      z = z + jra_pkg::ROUND_HALF;
      r.status = jra_pkg::STATUS_OK;
      r.angle = z[31 -: AB];
      return r;
   endfunction

   assign pending = angle_queue.size();

   always @(posedge clock) begin
      angle_result_type want;
      if (reset) begin
         cfg <= '{mid_x: 2048, mid_y: 2048, min_x: 0, max_x: 4095,
                  min_y: 0, max_y: 4095, dead_half_x: 256, dead_half_y: 256};
         angle_queue.delete();
         fail_count <= 0;
         ok_count <= 0;
         dead_count <= 0;
         bad_count <= 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[4:2])
               jra_pkg::REG_MID_X:  cfg.mid_x <= csr_pwdata[SB-1:0];
               jra_pkg::REG_MID_Y:  cfg.mid_y <= csr_pwdata[SB-1:0];
               jra_pkg::REG_MIN_X:  cfg.min_x <= csr_pwdata[SB-1:0];
               jra_pkg::REG_MAX_X:  cfg.max_x <= csr_pwdata[SB-1:0];
               jra_pkg::REG_MIN_Y:  cfg.min_y <= csr_pwdata[SB-1:0];
               jra_pkg::REG_MAX_Y:  cfg.max_y <= csr_pwdata[SB-1:0];
               jra_pkg::REG_DEAD_X: cfg.dead_half_x <= csr_pwdata[SB-1:0];
               jra_pkg::REG_DEAD_Y: cfg.dead_half_y <= csr_pwdata[SB-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            angle_queue.push_back(compute_angle(req_sample_x, req_sample_y));
         if (rsp_valid && !rsp_stall) begin
            if (angle_queue.size() == 0) begin
               $display("%0t: unexpected response status %0d angle %0d",
                        $time, rsp_status, rsp_angle);
               fail_count <= fail_count + 1;
            end else begin
               want = angle_queue.pop_front();
               case (want.status)
                  jra_pkg::STATUS_OK:   ok_count <= ok_count + 1;
                  jra_pkg::STATUS_DEAD: dead_count <= dead_count + 1;
                  default:              bad_count <= bad_count + 1;
               endcase
               if (want.status !== rsp_status || want.angle !== rsp_angle) begin
                  $display("%0t: status exp %0d got %0d, angle exp %0d got %0d",
                           $time, want.status, rsp_status, want.angle,
                           rsp_angle);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps
module testbench;

   localparam int SB = jra_pkg::SAMPLE_BITS;
   localparam int LATENCY = 22;
   localparam longint CYCLE_LIMIT = 200000;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic [SB-1:0]                 req_sample_x = '0;
   logic [SB-1:0]                 req_sample_y = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic [1:0]                    rsp_status;
   logic [jra_pkg::ANGLE_BITS-1:0] rsp_angle;
   logic                          csr_psel = 1'b0;
   logic                          csr_penable = 1'b0;
   logic                          csr_pwrite = 1'b0;
   logic [4:0]                    csr_paddr = '0;
   logic [31:0]                   csr_pwdata = '0;
   logic [31:0]                   csr_prdata;
   logic                          csr_pready;

   int     fail_count, pending, ok_count, dead_count, bad_count;
   longint cycle_count = 0;
   bit     quiet_tail = 1'b0;   // no idling on either side near the end
   int     request_count = 0;

   always #1 clock = ~clock;

   joystick_radial_angle i_dut (.*);

   angle_checker i_checker (.*);

   // give up if the run hangs
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // receiver: stall in random bursts, none in the quiet tail
   initial begin
      int gap;
      forever begin
         @(negedge clock);
         if (!quiet_tail && $urandom_range(0, 9) == 0) begin
            gap = $urandom_range(1, 16);
            rsp_stall <= 1'b1;
            repeat (gap) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // hold one request until accepted; payload stays put while stalled
   task automatic send_request(input logic [SB-1:0] sx,
                               input logic [SB-1:0] sy);
      int gap;
      if (!quiet_tail && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 16);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_sample_x <= sx;
      req_sample_y <= sy;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      request_count++;
      @(negedge clock);
   endtask

   // drain the pipe, then wait out its latency so the block is idle
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (LATENCY + 4) @(negedge clock);
   endtask

   // setup, access, then idle before the next transfer
   task automatic write_reg(input logic [jra_pkg::REG_BITS-1:0] idx, input int value);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= 32'(value);
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(negedge clock);
   endtask

   task automatic load_config(input int cx, cy, mnx, mxx, mny, mxy, hx, hy);
      wait_idle();
      write_reg(jra_pkg::REG_MID_X, cx);
      write_reg(jra_pkg::REG_MID_Y, cy);
      write_reg(jra_pkg::REG_MIN_X, mnx);
      write_reg(jra_pkg::REG_MAX_X, mxx);
      write_reg(jra_pkg::REG_MIN_Y, mny);
      write_reg(jra_pkg::REG_MAX_Y, mxy);
      write_reg(jra_pkg::REG_DEAD_X, hx);
      write_reg(jra_pkg::REG_DEAD_Y, hy);
   endtask

   // mostly moderate deflections around center, some full-range noise
   task automatic random_requests(input int count, input int cx, input int cy);
      int sx, sy;
      for (int k = 0; k < count; k++) begin
         if ($urandom_range(0, 3) == 0) begin
            sx = $urandom_range(0, 4095);
            sy = $urandom_range(0, 4095);
         end else begin
            sx = cx + $signed($urandom_range(0, 1200)) - 600;
            sy = cy + $signed($urandom_range(0, 1200)) - 600;
            sx = sx < 0 ? 0 : (sx > 4095 ? 4095 : sx);
            sy = sy < 0 ? 0 : (sy > 4095 ? 4095 : sy);
         end
         send_request(12'(sx), 12'(sy));
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: corners, axes, center, deadzone edge, exact diagonals
      send_request(12'd0, 12'd0);
      send_request(12'd4095, 12'd4095);
      send_request(12'd4095, 12'd0);
      send_request(12'd0, 12'd4095);
      send_request(12'd2048, 12'd2048);
      send_request(12'd2304, 12'd2048);
      send_request(12'd2305, 12'd2048);
      send_request(12'd2048, 12'd1792);
      send_request(12'd2048, 12'd1791);
      send_request(12'd4095, 12'd2048);
      send_request(12'd0, 12'd2048);
      send_request(12'd2048, 12'd4095);
      send_request(12'd2048, 12'd0);
      send_request(12'd3000, 12'd3000);
      send_request(12'd0, 12'd2047);
      send_request(12'd0, 12'd2049);
      send_request(12'hAAA, 12'h555);
      send_request(12'h555, 12'hAAA);

      // invalid settings: zero deadzone, center on a limit
      load_config(2048, 2048, 0, 4095, 0, 4095, 0, 256);
      send_request(12'd4095, 12'd0);
      load_config(4095, 2048, 0, 4095, 0, 4095, 100, 100);
      send_request(12'd100, 12'd100);
      load_config(2048, 0, 0, 4095, 0, 4095, 100, 100);
      send_request(12'd100, 12'd100);

      // tight ranges, minimal deadzone, skewed center
      load_config(1, 1, 0, 4095, 0, 2, 1, 1);
      random_requests(60, 1, 1);
      load_config(3000, 1000, 2500, 4094, 10, 3500, 4095, 1);
      random_requests(60, 3000, 1000);
      load_config(2000, 2100, 100, 3900, 50, 4000, 300, 150);
      random_requests(80, 2000, 2100);

      // pause until everything is back, then resume
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);

      load_config(2048, 2048, 0, 4095, 0, 4095, 40, 40);
      random_requests(130, 2048, 2048);
      quiet_tail = 1'b1;
      random_requests(100, 2048, 2048);

      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (LATENCY + 4) @(negedge clock);
      $display("sent %0d requests across 8 settings, incl. invalid and tight ranges",
               request_count);
      $display("responses: %0d angles, %0d deadzone, %0d invalid config",
               ok_count, dead_count, bad_count);
      if (fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule
